>>> rtl/mmsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multi-motor slew ramp block.
// No dependencies; every other file in rtl/ uses this package.
package mmsr_pkg;

	localparam int NUM_MOTORS    = 7;
	localparam int PULSE_BITS    = 12;
	localparam int MOTOR_BITS    = 3;
	localparam int PCT_BITS      = 7;
	localparam int CFG_IDX_BITS  = 2;
	localparam int FIFO_IDX_BITS = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int CNT_BITS      = $clog2(NUM_MOTORS + 1);

	localparam logic [PULSE_BITS-1:0] MAX_RESET   = PULSE_BITS'(2000);
	localparam logic [PULSE_BITS-1:0] MIN_RESET   = PULSE_BITS'(1000);
	localparam logic [PULSE_BITS-1:0] PULSE_RESET = PULSE_BITS'((2000 + 1000) / 2);
	localparam logic [PCT_BITS-1:0]   PCT_RESET   = PCT_BITS'(10);
	localparam logic [PCT_BITS-1:0]   PCT_DEFAULT = PCT_BITS'(10);
	localparam logic [PCT_BITS-1:0]   PCT_FULL    = PCT_BITS'(100);

	// floor(x / 100) via reciprocal, low by at most one, fixed by one compare
	localparam int PROD_BITS   = PULSE_BITS + PCT_BITS;
	localparam int RECIP_BITS  = PROD_BITS - 6;
	localparam int RECIP_SHIFT = PROD_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((64'd1 << PROD_BITS) / 100);
	localparam logic [PROD_BITS-1:0]  DIVISOR = PROD_BITS'(100);

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MAX_PULSE    = 2'd0,
		REG_MIN_PULSE    = 2'd1,
		REG_STEP_PERCENT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [MOTOR_BITS-1:0] motor_sel;
		logic [PULSE_BITS-1:0] target_pulse;
	} in_item_t;

	typedef struct packed {
		logic [MOTOR_BITS-1:0] motor_out;
		logic [PULSE_BITS-1:0] pulse_out;
		logic                  reached;
		logic                  ticks_needed;
	} out_item_t;

	typedef struct packed {
		logic                  busy;
		logic [PULSE_BITS-1:0] max_pulse;
		logic [PULSE_BITS-1:0] min_pulse;
		logic [PULSE_BITS-1:0] step;
	} limits_t;

endpackage

>>> rtl/mmsr_step_calc.sv
`timescale 1ns / 1ps
// Configuration registers and the ramp step pipeline (range * percent / 100).
// Depends on mmsr_pkg.
module mmsr_step_calc (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mmsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mmsr_pkg::PULSE_BITS-1:0]   cfg_data,
	output mmsr_pkg::limits_t                 limits
);

	localparam logic [1:0] SETTLE = 2'd3;

	logic [mmsr_pkg::PULSE_BITS-1:0] max_q, min_q;
	logic [mmsr_pkg::PCT_BITS-1:0]   pct_q;
	logic [1:0]                      settle_q;

	logic [mmsr_pkg::PULSE_BITS-1:0] range;
	logic [mmsr_pkg::PCT_BITS-1:0]   pct_eff;
	logic [mmsr_pkg::PROD_BITS-1:0]  prod_s1, prod_s2, rem;
	logic [mmsr_pkg::PULSE_BITS-1:0] quot_s2, quot_fix, step_q;
	logic [mmsr_pkg::PROD_BITS+mmsr_pkg::RECIP_BITS-1:0] recip_prod;
	logic                            cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= mmsr_pkg::MAX_RESET;
			min_q    <= mmsr_pkg::MIN_RESET;
			pct_q    <= mmsr_pkg::PCT_RESET;
			settle_q <= SETTLE;
		end else if (cfg_wr) begin
			settle_q <= SETTLE;
			case (mmsr_pkg::reg_idx_t'(cfg_index))
				mmsr_pkg::REG_MAX_PULSE:    max_q <= cfg_data;
				mmsr_pkg::REG_MIN_PULSE:    min_q <= cfg_data;
				mmsr_pkg::REG_STEP_PERCENT: pct_q <= cfg_data[mmsr_pkg::PCT_BITS-1:0];
				default: ;
			endcase
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	always_comb begin
		range = (max_q > min_q) ? (max_q - min_q) : '0;
		if (pct_q == '0)
			pct_eff = mmsr_pkg::PCT_DEFAULT;
		else if (pct_q > mmsr_pkg::PCT_FULL)
			pct_eff = mmsr_pkg::PCT_FULL;
		else
			pct_eff = pct_q;
		recip_prod = prod_s1 * mmsr_pkg::RECIP;
		rem        = prod_s2 - mmsr_pkg::PROD_BITS'(quot_s2 * mmsr_pkg::DIVISOR);
		quot_fix   = (rem >= mmsr_pkg::DIVISOR) ? quot_s2 + 1'b1 : quot_s2;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mmsr_pkg::PROD_BITS'(range) * mmsr_pkg::PROD_BITS'(pct_eff);
		prod_s2 <= prod_s1;
		quot_s2 <= mmsr_pkg::PULSE_BITS'(recip_prod >> mmsr_pkg::RECIP_SHIFT);
		step_q  <= (quot_fix == '0) ? mmsr_pkg::PULSE_BITS'(1) : quot_fix;
	end

	assign limits.busy      = (settle_q != 2'd0);
	assign limits.max_pulse = max_q;
	assign limits.min_pulse = min_q;
	assign limits.step      = step_q;

endmodule

>>> rtl/mmsr_motor_core.sv
`timescale 1ns / 1ps
// Per-motor pulse state, pending queue and the combinational ramp update.
// Depends on mmsr_pkg.
module mmsr_motor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  mmsr_pkg::in_item_t item,
	input  mmsr_pkg::limits_t  limits,
	output logic               has_result,
	output mmsr_pkg::out_item_t result
);

	localparam int N  = mmsr_pkg::NUM_MOTORS;
	localparam int IB = mmsr_pkg::FIFO_IDX_BITS;
	localparam int CB = mmsr_pkg::CNT_BITS;
	localparam int PB = mmsr_pkg::PULSE_BITS;
	localparam int MB = mmsr_pkg::MOTOR_BITS;

	logic [PB-1:0] cur_q [N];
	logic [PB-1:0] tgt_q [N];
	logic [MB-1:0] fifo_q [N];
	logic [N-1:0]  pend_q;
	logic [IB-1:0] head_q;
	logic [CB-1:0] count_q;

	logic          is_tick, en;
	logic [MB-1:0] head_m, sel_m;
	logic [IB-1:0] m_idx, head1, slot;
	logic [CB-1:0] count1, count2;
	logic [CB:0]   slot_sum;
	logic [N-1:0]  pend1, pend2;
	logic [PB-1:0] clamped, tgt_new, cur_old, cur_new, s;
	logic          done;

	always_comb begin
		is_tick = (item.cmd == mmsr_pkg::CMD_TICK);
		head_m  = fifo_q[head_q];
		if (32'(head_m) >= N)
			head_m = '0;
		sel_m = is_tick ? head_m : item.motor_sel;
		m_idx = IB'(sel_m);
		has_result = is_tick ? (count_q != '0) : (32'(item.motor_sel) < N);

		clamped = item.target_pulse;
		if (clamped > limits.max_pulse)
			clamped = limits.max_pulse;
		if (clamped < limits.min_pulse)
			clamped = limits.min_pulse;
		tgt_new = is_tick ? tgt_q[m_idx] : clamped;

		s       = limits.step;
		cur_old = cur_q[m_idx];
		if (cur_old < tgt_new)
			cur_new = (tgt_new - cur_old <= s) ? tgt_new : cur_old + s;
		else if (cur_old > tgt_new)
			cur_new = (cur_old - tgt_new <= s) ? tgt_new : cur_old - s;
		else
			cur_new = cur_old;
		done = (cur_new == tgt_new);

		pend1  = pend_q;
		head1  = head_q;
		count1 = count_q;
		if (is_tick) begin
			pend1[m_idx] = 1'b0;
			head1  = (32'(head_q) == N - 1) ? '0 : head_q + 1'b1;
			count1 = count_q - 1'b1;
		end
		en       = !done && !pend1[m_idx] && (32'(count1) < N);
		slot_sum = (CB+1)'(head1) + (CB+1)'(count1);
		if (32'(slot_sum) >= N)
			slot_sum = slot_sum - (CB+1)'(N);
		slot   = IB'(slot_sum);
		pend2  = pend1;
		if (en)
			pend2[m_idx] = 1'b1;
		count2 = count1 + CB'(en);

		result.motor_out    = sel_m;
		result.pulse_out    = cur_new;
		result.reached      = done;
		result.ticks_needed = (count2 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				cur_q[i] <= mmsr_pkg::PULSE_RESET;
				tgt_q[i] <= mmsr_pkg::PULSE_RESET;
			end
			pend_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
		end else if (fire && has_result) begin
			cur_q[m_idx] <= cur_new;
			tgt_q[m_idx] <= tgt_new;
			pend_q  <= pend2;
			head_q  <= head1;
			count_q <= count2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result && en)
			fifo_q[slot] <= sel_m;
	end

endmodule

>>> rtl/multi_motor_slew_ramp_core.sv
`timescale 1ns / 1ps
// Top level of the multi-motor slew ramp block: input register, update core, result register.
// Depends on mmsr_pkg, mmsr_step_calc and mmsr_motor_core.
//
// Use: the cfg channel writes max_pulse (index 0), min_pulse (1) and
// step_percent (2); write only while the block is idle. A write
// reaches step_q via prod_s1 and quot_s2; in_ready stays low meanwhile.
// Each request on the in channel is either a set (new target for one
// motor) or a timer tick (step the motor at the head of the queue).
// A request sits in the input register, where the core reads and
// updates the motor state, and its result lands in the output register.
// One request is taken per cycle while out_ready is high and no cfg
// write is settling; the state update of one request is written as it
// leaves the input register, so the next one sees it with no stall.
// A set for a motor index out of range and a tick with an empty queue
// give no result. While out_ready is low one result waits in the output
// register and one request in the input register; in_ready then drops.
// Reset puts all motors at pulse 1500, empties the queue, restores the
// register defaults and holds in_ready low until settle_q runs out.
module multi_motor_slew_ramp_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mmsr_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mmsr_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mmsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mmsr_pkg::PULSE_BITS-1:0]   cfg_data
);

	mmsr_pkg::limits_t   limits;
	mmsr_pkg::in_item_t  item_s1;
	mmsr_pkg::out_item_t result, out_q;
	logic                valid_s1, out_valid_q, has_result, advance;

	mmsr_step_calc u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	mmsr_motor_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.item       (item_s1),
		.limits     (limits),
		.has_result (has_result),
		.result     (result)
	);

	assign advance  = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready = !limits.busy && (!valid_s1 || advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance && has_result)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (advance && has_result)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> tb/sv/multi_motor_slew_ramp_core_test.sv
`timescale 1ns / 1ps
// Testbench for multi_motor_slew_ramp_core: directed and random set/tick requests under
// random back-pressure, checked against an in-bench slew predictor across limit settings.
// Depends on mmsr_pkg and the RTL of the block only.
module multi_motor_slew_ramp_core_test;
	import mmsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
	localparam logic [MOTOR_BITS-1:0]   MOTOR_BAD = 3'd7;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	in_item_t                in_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	out_item_t               out_data;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [PULSE_BITS-1:0]   cfg_data = '0;

	// predictor state
	logic [PULSE_BITS-1:0] lim_max;
	logic [PULSE_BITS-1:0] lim_min;
	logic [PCT_BITS-1:0]   pct_reg;
	int unsigned cur_pulse [NUM_MOTORS];
	int unsigned tgt_pulse [NUM_MOTORS];
	int unsigned pend_fifo [NUM_MOTORS];
	bit          pend_flag [NUM_MOTORS];
	int unsigned fifo_head;
	int unsigned fifo_cnt;

	out_item_t ramp_expect_q [$];
	int err_count = 0;
	int sent_items = 0;
	int idle_cycles = 0;

	multi_motor_slew_ramp_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_predictor();
		lim_max = MAX_RESET;
		lim_min = MIN_RESET;
		pct_reg = PCT_RESET;
		for (int m = 0; m < NUM_MOTORS; m++) begin
			cur_pulse[m] = PULSE_RESET;
			tgt_pulse[m] = PULSE_RESET;
			pend_fifo[m] = 0;
			pend_flag[m] = 1'b0;
		end
		fifo_head = 0;
		fifo_cnt = 0;
	endfunction

	function automatic int unsigned ramp_step_size();
		int unsigned span;
		int unsigned pct;
		int unsigned s;
		span = (lim_max > lim_min) ? (lim_max - lim_min) : 0;
		pct = pct_reg;
		if (pct == 0) pct = PCT_DEFAULT;
		if (pct > PCT_FULL) pct = PCT_FULL;
		s = span * pct / PCT_FULL;
		return (s == 0) ? 1 : s;
	endfunction

	function automatic bit move_toward_target(int unsigned m);
		int unsigned s;
		int unsigned c;
		int unsigned t;
		s = ramp_step_size();
		c = cur_pulse[m];
		t = tgt_pulse[m];
		if (c < t) begin
			c = (t - c <= s) ? t : c + s;
		end else if (c > t) begin
			c = (c - t <= s) ? t : c - s;
		end
		cur_pulse[m] = c;
		return c == t;
	endfunction

	function automatic void queue_motor(int unsigned m);
		if (pend_flag[m] || fifo_cnt >= NUM_MOTORS) return;
		pend_fifo[(fifo_head + fifo_cnt) % NUM_MOTORS] = m;
		pend_flag[m] = 1'b1;
		fifo_cnt++;
	endfunction

	function automatic int unsigned pop_motor();
		int unsigned m;
		m = pend_fifo[fifo_head % NUM_MOTORS];
		if (m >= NUM_MOTORS) m = 0;
		fifo_head = (fifo_head + 1) % NUM_MOTORS;
		fifo_cnt--;
		pend_flag[m] = 1'b0;
		return m;
	endfunction

	// returns 1 when the request produces a result
	function automatic bit predict_ramp(input in_item_t req, output out_item_t res);
		int unsigned m;
		int unsigned v;
		bit done;
		res = '0;
		if (req.cmd == CMD_TICK) begin
			if (fifo_cnt == 0) return 1'b0;
			m = pop_motor();
		end else begin
			m = req.motor_sel;
			if (m >= NUM_MOTORS) return 1'b0;
			v = req.target_pulse;
			if (v > lim_max) v = lim_max;
			if (v < lim_min) v = lim_min;
			tgt_pulse[m] = v;
		end
		done = move_toward_target(m);
		if (!done) queue_motor(m);
		res.motor_out = MOTOR_BITS'(m);
		res.pulse_out = PULSE_BITS'(cur_pulse[m]);
		res.reached = done;
		res.ticks_needed = (fifo_cnt > 0);
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic in_item_t set_request(int unsigned m, int unsigned t);
		in_item_t r;
		r.cmd = CMD_SET;
		r.motor_sel = MOTOR_BITS'(m);
		r.target_pulse = PULSE_BITS'(t);
		return r;
	endfunction

	function automatic in_item_t tick_request();
		in_item_t r;
		r.cmd = CMD_TICK;
		r.motor_sel = MOTOR_BITS'($urandom_range(0, 7));
		r.target_pulse = PULSE_BITS'($urandom_range(0, 4095));
		return r;
	endfunction

	function automatic int unsigned rand_target();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 0;
		if (r < 20) return 4095;
		if (r < 30) return lim_min;
		if (r < 40) return lim_max;
		return $urandom_range(0, 4095);
	endfunction

	function automatic in_item_t rand_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return set_request($urandom_range(0, 7), $urandom_range(0, 4095));
		if (r < 45) return set_request(MOTOR_BAD, $urandom_range(0, 4095));
		return tick_request();
	endfunction

	// entered and left at a falling edge; in_valid stays high for a back-to-back request
	task automatic send_request(in_item_t req);
		int gap;
		out_item_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
		if (predict_ramp(req, res)) begin
			ramp_expect_q.push_back(res);
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (ramp_expect_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PULSE_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_MAX_PULSE:    lim_max = val;
			REG_MIN_PULSE:    lim_min = val;
			REG_STEP_PERCENT: pct_reg = val[PCT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_limits(int unsigned mx, int unsigned mn, int unsigned pct);
		wait_idle();
		write_reg(REG_MAX_PULSE, PULSE_BITS'(mx));
		write_reg(REG_MIN_PULSE, PULSE_BITS'(mn));
		write_reg(REG_STEP_PERCENT, PULSE_BITS'(pct));
	endtask

	// mostly set bursts followed by tick runs, some noise
	task automatic run_ramp_traffic(int n);
		int start;
		int k;
		start = sent_items;
		while (sent_items - start < n) begin
			if ($urandom_range(0, 99) < 80) begin
				k = $urandom_range(1, 3);
				repeat (k) send_request(set_request($urandom_range(0, NUM_MOTORS - 1),
					rand_target()));
				k = $urandom_range(1, 12);
				repeat (k) send_request(tick_request());
			end else begin
				send_request(rand_request());
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_request(tick_request());
		send_request(set_request(0, PULSE_RESET));
		send_request(set_request(MOTOR_BAD, 4095));
		send_request(tick_request());
		send_request(set_request(5, PULSE_RESET + 50));
		send_request(tick_request());
	endtask

	task automatic test_clamp_and_ramp();
		send_request(set_request(1, 4095));
		send_request(set_request(2, 0));
		send_request(set_request(1, 4095));
		send_request(set_request(6, 12'h800));
		send_request(set_request(3, 2000));
		// lands on target while still queued
		send_request(set_request(3, 1650));
		repeat (14) send_request(tick_request());
	endtask

	task automatic test_limit_settings();
		int unsigned max_set [11] = '{4095, 4095, 1200, 1000, 3000, 2500, 2048, 0, 4095, 4095, 2000};
		int unsigned min_set [11] = '{0, 0, 1150, 1100, 500, 2000, 1024, 0, 4095, 0, 1000};
		int unsigned pct_set [11] = '{100, 1, 1, 50, 0, 127, 12'hF85, 101, 100, 3, 10};
		wait_idle();
		write_reg(REG_SPARE, PULSE_BITS'($urandom_range(0, 4095)));
		for (int i = 0; i < 11; i++) begin
			apply_limits(max_set[i], min_set[i], pct_set[i]);
			run_ramp_traffic(100);
		end
	endtask

	task automatic test_pause_until_idle();
		repeat (6) begin
			repeat (10) send_request(rand_request());
			wait_idle();
		end
	endtask

	task automatic report_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (out_valid && out_ready) begin
			if (ramp_expect_q.size() == 0) begin
				$display("%0t: unexpected result motor %0d pulse %0d", $time,
					out_data.motor_out, out_data.pulse_out);
				err_count++;
			end else begin
				want = ramp_expect_q.pop_front();
				report_field("motor_out", want.motor_out, out_data.motor_out);
				report_field("pulse_out", want.pulse_out, out_data.pulse_out);
				report_field("reached", want.reached, out_data.reached);
				report_field("ticks_needed", want.ticks_needed, out_data.ticks_needed);
			end
		end
	end

	initial begin : sink_pacing
		int r;
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end else if (r < 90) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[multi_motor_slew_ramp_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_predictor();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_clamp_and_ramp();
		test_limit_settings();
		test_pause_until_idle();
		wait_idle();
		repeat (8) @(negedge clk);
		if (ramp_expect_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, ramp_expect_q.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("[multi_motor_slew_ramp_core] OK");
		end else begin
			$display("[multi_motor_slew_ramp_core] ERROR");
		end
		$finish;
	end

endmodule
